// ===== src/mhmx_pkg.sv =====
// Package for the min-heap with max extract: capacity, derived widths,
// operation and status codes, and the command and response item types.
// Depends on nothing; every other file imports it.
package mhmx_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_GET_MIN = 2'd1;
    localparam logic [1:0] OP_GET_MAX = 2'd2;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_VALUE    = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
    } rsp_item_t;

endpackage

// ===== src/mhmx_rsp_buf.sv =====
// Response holding register for the min-heap block: keeps one finished
// item until the receiver takes it. Depends on mhmx_pkg.
module mhmx_rsp_buf
    import mhmx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rsp_item_t push_item,
    output logic      ready,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    logic      valid_reg;
    logic      valid_next;
    rsp_item_t item_reg;

    assign ready     = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp       = item_reg;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !rsp_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg <= push_item;
        end
    end

endmodule

// ===== src/min_heap_with_max_extract.sv =====
// Min-heap of signed 32-bit values with min and max extraction.
// Depends on mhmx_pkg and mhmx_rsp_buf.
//
// Usage: an item on the cmd channel (cmd_valid, cmd_stall, cmd) carries an
// operation and a value. Every item gives exactly one item on the rsp
// channel (rsp_valid, rsp_stall, rsp) with a status and, for a successful
// get, the removed value. The block works on one item at a time and holds
// cmd_stall high from the cycle after acceptance until the result is handed
// to the output register. Steps: empty, full or unused-code items go straight
// to the finish state; an insert sifts the value up from the new last slot;
// get-min reads the root and, unless that empties the heap, moves the last
// entry to the root and sifts it down; get-max scans the leaves for the
// largest value and, unless that was the last entry, moves the last entry
// into its slot and sifts it up as an insert does. The memory has one read
// port with a registered read and one write port, and the block has one
// shared comparator. A stalled result waits in the output register while the
// next item runs; the block waits at its end only if that register is still
// full.
// Reset empties the heap at once; the memory contents need no clearing.
module min_heap_with_max_extract
    import mhmx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_DISPATCH = 15'h0002,
        S_SU_RD    = 15'h0004,
        S_SU_CMP   = 15'h0008,
        S_MIN_LAST = 15'h0010,
        S_MIN_MOVE = 15'h0020,
        S_SD_CHK   = 15'h0040,
        S_SD_RDR   = 15'h0080,
        S_SD_SEL   = 15'h0100,
        S_SD_CMP   = 15'h0200,
        S_MX_FIRST = 15'h0400,
        S_MX_SCAN  = 15'h0800,
        S_MX_LAST  = 15'h1000,
        S_MX_MOVE  = 15'h2000,
        S_FINISH   = 15'h4000
    } state_t;

    localparam int CHILD_W = IDX_W + 2;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [1:0]               op_reg, op_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [1:0]               status_reg, status_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic [CNT_W-1:0]         scan_reg, scan_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic signed [DATA_W-1:0] lval_reg, lval_next;
    logic signed [DATA_W-1:0] child_val_reg, child_val_next;
    logic [IDX_W-1:0]         child_idx_reg, child_idx_next;

    logic signed [DATA_W-1:0] heap_mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]         mem_raddr;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;

    logic signed [DATA_W-1:0] cmp_a, cmp_b;
    logic                     cmp_lt;

    logic [CNT_W-1:0]         cnt_m1;
    logic [IDX_W-1:0]         pos_m1;
    logic [IDX_W-1:0]         parent_idx;
    logic [CHILD_W-1:0]       left_idx, right_idx, count_wide;
    logic                     left_in, right_in;
    logic [IDX_W-1:0]         half_idx;

    logic                     buf_push;
    logic                     buf_ready;
    rsp_item_t                buf_item;

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign pos_m1     = pos_reg - IDX_W'(1);
    assign parent_idx = pos_m1 >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + CHILD_W'(1);
    assign count_wide = CHILD_W'(count_reg);
    assign left_in    = left_idx < count_wide;
    assign right_in   = right_idx < count_wide;
    assign half_idx   = IDX_W'(count_reg >> 1);

    assign cmd_stall = (state_reg != S_IDLE);

    // The one comparator of the block; each state picks its operands.
    always_comb
    begin
        case (state_reg)
            S_SD_SEL:
            begin
                cmp_a = rd_data_reg;
                cmp_b = lval_reg;
            end
            S_SD_CMP:
            begin
                cmp_a = child_val_reg;
                cmp_b = cur_reg;
            end
            S_MX_SCAN:
            begin
                cmp_a = best_val_reg;
                cmp_b = rd_data_reg;
            end
            default:
            begin
                cmp_a = cur_reg;
                cmp_b = rd_data_reg;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        scan_next      = scan_reg;
        rd_idx_next    = rd_idx_reg;
        lval_next      = lval_reg;
        child_val_next = child_val_reg;
        child_idx_next = child_idx_reg;
        mem_raddr      = '0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = cur_reg;
        buf_push       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd.operation;
                    cur_next   = cmd.value;
                    res_next   = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            status_next = ST_INSERTED;
                            pos_next    = IDX_W'(count_reg);
                            count_next  = count_reg + CNT_W'(1);
                            state_next  = S_SU_RD;
                        end
                    end
                    OP_GET_MIN:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            state_next = S_MIN_LAST;
                        end
                    end
                    OP_GET_MAX:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            mem_raddr     = half_idx;
                            best_idx_next = half_idx;
                            scan_next     = (count_reg >> 1) + CNT_W'(1);
                            state_next    = S_MX_FIRST;
                        end
                    end
                    default:
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            // Sift-up keeps a hole at pos_reg and writes the moving value last.
            S_SU_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr  = parent_idx;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    mem_wdata  = rd_data_reg;
                    pos_next   = parent_idx;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MIN_LAST:
            begin
                res_next    = rd_data_reg;
                status_next = ST_VALUE;
                count_next  = cnt_m1;
                if (cnt_m1 == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr  = IDX_W'(cnt_m1);
                    state_next = S_MIN_MOVE;
                end
            end
            S_MIN_MOVE:
            begin
                cur_next   = rd_data_reg;
                pos_next   = '0;
                state_next = S_SD_CHK;
            end
            S_SD_CHK:
            begin
                if (!left_in)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr  = IDX_W'(left_idx);
                    state_next = S_SD_RDR;
                end
            end
            S_SD_RDR:
            begin
                lval_next = rd_data_reg;
                if (right_in)
                begin
                    mem_raddr = IDX_W'(right_idx);
                end
                state_next = S_SD_SEL;
            end
            S_SD_SEL:
            begin
                // On a tie the left child wins.
                if (right_in && cmp_lt)
                begin
                    child_val_next = rd_data_reg;
                    child_idx_next = IDX_W'(right_idx);
                end
                else
                begin
                    child_val_next = lval_reg;
                    child_idx_next = IDX_W'(left_idx);
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_lt)
                begin
                    mem_wdata  = child_val_reg;
                    pos_next   = child_idx_reg;
                    state_next = S_SD_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MX_FIRST:
            begin
                best_val_next = rd_data_reg;
                if (scan_reg < count_reg)
                begin
                    mem_raddr   = IDX_W'(scan_reg);
                    rd_idx_next = IDX_W'(scan_reg);
                    scan_next   = scan_reg + CNT_W'(1);
                    state_next  = S_MX_SCAN;
                end
                else
                begin
                    state_next = S_MX_LAST;
                end
            end
            S_MX_SCAN:
            begin
                // The first slot keeps a tie.
                if (cmp_lt)
                begin
                    best_val_next = rd_data_reg;
                    best_idx_next = rd_idx_reg;
                end
                if (scan_reg < count_reg)
                begin
                    mem_raddr   = IDX_W'(scan_reg);
                    rd_idx_next = IDX_W'(scan_reg);
                    scan_next   = scan_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_MX_LAST;
                end
            end
            S_MX_LAST:
            begin
                res_next    = best_val_reg;
                status_next = ST_VALUE;
                count_next  = cnt_m1;
                if (CNT_W'(best_idx_reg) == cnt_m1)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr  = IDX_W'(cnt_m1);
                    state_next = S_MX_MOVE;
                end
            end
            S_MX_MOVE:
            begin
                cur_next   = rd_data_reg;
                pos_next   = best_idx_reg;
                state_next = S_SU_RD;
            end
            S_FINISH:
            begin
                if (buf_ready)
                begin
                    buf_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        best_idx_reg  <= best_idx_next;
        best_val_reg  <= best_val_next;
        scan_reg      <= scan_next;
        rd_idx_reg    <= rd_idx_next;
        lval_reg      <= lval_next;
        child_val_reg <= child_val_next;
        child_idx_reg <= child_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= heap_mem[mem_raddr];
    end

    assign buf_item.result_value = res_reg;
    assign buf_item.status       = status_reg;

    mhmx_rsp_buf u_rsp_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (buf_push),
        .push_item (buf_item),
        .ready     (buf_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap count exceeds capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("heap count moved by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("heap write beyond the valid entries");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted item was not dispatched");

    a_push_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        buf_push |-> buf_ready && (state_reg == S_FINISH))
        else $error("result pushed into a full output register");
`endif

endmodule
